// ===== hw/rtl/lcaq_pkg.sv =====
// shared constants and codes for the lowest common ancestor query unit
`default_nettype none

package lcaq_pkg;

  // node index width and parent store geometry
  localparam int NODE_W      = 8;
  localparam int STORE_DEPTH = 256;
  localparam int ENTRY_W     = NODE_W + 1;

  // request codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

endpackage

`default_nettype wire

// ===== hw/rtl/lcaq_if.sv =====
// request and response channel interfaces of the lowest common ancestor query unit
`default_nettype none

interface lcaq_req_if
  import lcaq_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [NODE_W-1:0] node_a;
  logic [NODE_W-1:0] node_b;
  logic [NODE_W-1:0] parent_index;
  logic              has_parent;

  modport source (output valid, req_type, node_a, node_b, parent_index, has_parent,
                  input ready);
  modport sink   (input valid, req_type, node_a, node_b, parent_index, has_parent,
                  output ready);
endinterface

interface lcaq_rsp_if
  import lcaq_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] ancestor;
  logic              found;

  modport source (output valid, ancestor, found, input ready);
  modport sink   (input valid, ancestor, found, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lowest_common_ancestor_query_unit.sv =====
// top level: parent table memory and ancestor walk sequencer
`default_nettype none

// Keeps a 256-entry parent table (valid bit plus parent index) in one synchronous
// memory and answers lowest common ancestor queries by walking the larger cursor up
// to its parent until both cursors meet. A write word (req_type 0) is taken while
// the unit is idle and gives no response. A query word gives exactly one response
// word; each parent move is one memory read and its registered return, and equal
// nodes answer with no move at all. The unit works on one word at a time, and a
// finished response sits in the output register, so the next request word is
// taken while it waits. Queries on nodes in different trees, on nodes at or above
// MAX_NODES, or that need more than 2*MAX_NODES moves report found = 0 and
// ancestor = 0. The table needs no clearing after reset; entries read on a walk
// must have been written first.
module lowest_common_ancestor_query_unit
  import lcaq_pkg::*;
#(
  parameter int MAX_NODES = 256
) (
  input  wire         clk,
  input  wire         rst,
  lcaq_req_if.sink    req,
  lcaq_rsp_if.source  rsp
);

  localparam int STEP_W   = $clog2(2 * MAX_NODES + 1);
  localparam int ADDR_W   = $clog2(STORE_DEPTH);
  localparam logic [STEP_W-1:0] STEP_BOUND = STEP_W'(2 * MAX_NODES);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]         state;
  logic [NODE_W-1:0]  cursor_first;
  logic [NODE_W-1:0]  cursor_second;
  logic [STEP_W-1:0]  step_count;
  logic               mover_first;
  logic [NODE_W-1:0]  res_ancestor;
  logic               res_found;
  logic               out_valid;
  logic [NODE_W-1:0]  out_ancestor;
  logic               out_found;

  logic [ENTRY_W-1:0] parent_store [STORE_DEPTH];
  logic [ENTRY_W-1:0] rd_data;
  logic               wr_en;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic               accept;
  logic               move_first;

  function automatic logic node_ok(input logic [NODE_W-1:0] node);
    return 32'(node) < 32'(MAX_NODES);
  endfunction

  // handshake
  assign req.ready    = (state == S_IDLE);
  assign accept       = req.valid && req.ready;
  assign rsp.valid    = out_valid;
  assign rsp.ancestor = out_ancestor;
  assign rsp.found    = out_found;

  // memory control: writes only while idle, reads only during the walk
  assign wr_en      = accept && (req.req_type == REQ_WRITE) && node_ok(req.node_a);
  assign move_first = cursor_first > cursor_second;
  assign rd_en      = (state == S_CHECK);
  assign rd_addr    = ADDR_W'(move_first ? cursor_first : cursor_second);

  // parent table memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      parent_store[ADDR_W'(req.node_a)] <= {req.has_parent, req.parent_index};
    end
    if (rd_en) begin
      rd_data <= parent_store[rd_addr];
    end
  end

  // walk sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cursor_first  <= '0;
      cursor_second <= '0;
      step_count    <= '0;
      out_valid     <= 1'b0;
    end else begin
      // output word taken; a new word loaded in S_DONE takes its place
      if (out_valid && rsp.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && (req.req_type == REQ_QUERY)) begin
            cursor_first  <= req.node_a;
            cursor_second <= req.node_b;
            step_count    <= '0;
            if (node_ok(req.node_a) && node_ok(req.node_b)) begin
              state <= S_CHECK;
            end else begin
              res_found    <= 1'b0;
              res_ancestor <= '0;
              state        <= S_DONE;
            end
          end
        end
        S_CHECK: begin
          if (cursor_first == cursor_second) begin
            res_found    <= 1'b1;
            res_ancestor <= cursor_first;
            state        <= S_DONE;
          end else if (step_count >= STEP_BOUND) begin
            res_found    <= 1'b0;
            res_ancestor <= '0;
            state        <= S_DONE;
          end else begin
            mover_first <= move_first;
            state       <= S_READ;
          end
        end
        S_READ: begin
          // a root on the moving side or a parent out of range ends the walk
          if (!rd_data[NODE_W] || !node_ok(rd_data[NODE_W-1:0])) begin
            res_found    <= 1'b0;
            res_ancestor <= '0;
            state        <= S_DONE;
          end else begin
            if (mover_first) begin
              cursor_first <= rd_data[NODE_W-1:0];
            end else begin
              cursor_second <= rd_data[NODE_W-1:0];
            end
            step_count <= step_count + 1'b1;
            state      <= S_CHECK;
          end
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid    <= 1'b1;
            out_ancestor <= res_ancestor;
            out_found    <= res_found;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== bench/lowest_common_ancestor_query_unit_tb.sv =====
// self-checking testbench for the lowest common ancestor query unit
`timescale 1ns / 100ps

module lowest_common_ancestor_query_unit_tb;
  import lcaq_pkg::*;

  localparam int MAX_NODES = 256;
  // a walk is one memory read and its registered return per parent move, plus start and finish
  localparam int WALK_CYCLES = 4 * MAX_NODES + 8;
  localparam int HOLD_OFF_CYCLES = 400;

  typedef struct packed {
    logic              req_type;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic [NODE_W-1:0] parent_index;
    logic              has_parent;
  } lca_word_t;

  typedef struct packed {
    logic [NODE_W-1:0] ancestor;
    logic              found;
  } lca_answer_t;

  typedef enum logic [1:0] {RX_OPEN, RX_THIRDS, RX_COIN, RX_MOSTLY} rx_mode_e;

  logic clk;
  logic rst;

  lcaq_req_if req_ch ();
  lcaq_rsp_if rsp_ch ();

  lowest_common_ancestor_query_unit #(
    .MAX_NODES(MAX_NODES)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // shadow parent table: valid bit over parent index
  logic [ENTRY_W-1:0] parent_tbl [STORE_DEPTH];

  lca_word_t   pending_words[$];
  lca_answer_t expected_answers[$];

  int errors = 0;
  int n_writes = 0;
  int n_queries = 0;
  int n_answers = 0;
  int n_found = 0;
  int n_missed = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // walk both cursors upward, always moving the larger one, until they meet
  function automatic lca_answer_t walk_to_meet(logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
    int unsigned cur_a;
    int unsigned cur_b;
    int unsigned moves;
    logic [ENTRY_W-1:0] entry;
    lca_answer_t ans;
    ans = '0;
    cur_a = 32'(a);
    cur_b = 32'(b);
    moves = 0;
    if (cur_a >= MAX_NODES || cur_b >= MAX_NODES) return ans;
    while (cur_a != cur_b) begin
      if (moves >= 2 * MAX_NODES) return ans;
      if (cur_a > cur_b) begin
        entry = parent_tbl[cur_a[NODE_W-1:0]];
        if (!entry[NODE_W]) return ans;
        cur_a = 32'(entry[NODE_W-1:0]);
        moves++;
        if (cur_a >= MAX_NODES) return ans;
      end else begin
        entry = parent_tbl[cur_b[NODE_W-1:0]];
        if (!entry[NODE_W]) return ans;
        cur_b = 32'(entry[NODE_W-1:0]);
        moves++;
        if (cur_b >= MAX_NODES) return ans;
      end
    end
    ans.found = 1'b1;
    ans.ancestor = cur_a[NODE_W-1:0];
    return ans;
  endfunction

  // update the shadow table or queue the expected answer for one accepted word
  task automatic apply_word(lca_word_t w);
    if (w.req_type == REQ_WRITE) begin
      n_writes++;
      if (w.node_a < MAX_NODES) parent_tbl[w.node_a] = {w.has_parent, w.parent_index};
    end else begin
      n_queries++;
      expected_answers.insert(expected_answers.size(), walk_to_meet(w.node_a, w.node_b));
    end
  endtask

  task automatic push_write(int node, int par, bit hp);
    lca_word_t w;
    w.req_type = REQ_WRITE;
    w.node_a = node[NODE_W-1:0];
    w.node_b = NODE_W'($urandom_range(255));
    w.parent_index = par[NODE_W-1:0];
    w.has_parent = hp;
    pending_words.insert(pending_words.size(), w);
  endtask

  task automatic push_query(int a, int b);
    lca_word_t w;
    w.req_type = REQ_QUERY;
    w.node_a = a[NODE_W-1:0];
    w.node_b = b[NODE_W-1:0];
    w.parent_index = NODE_W'($urandom_range(255));
    w.has_parent = 1'($urandom_range(1));
    pending_words.insert(pending_words.size(), w);
  endtask

  // request driver: bursts of words separated by random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin : drive_words
    lca_word_t w;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (req_ch.valid) begin
        w.req_type = req_ch.req_type;
        w.node_a = req_ch.node_a;
        w.node_b = req_ch.node_b;
        w.parent_index = req_ch.parent_index;
        w.has_parent = req_ch.has_parent;
        apply_word(w);
      end
      if (gap_left > 0 || pending_words.size() == 0) begin
        if (gap_left > 0) gap_left--;
        req_ch.valid <= 1'b0;
      end else begin
        w = pending_words.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.req_type <= w.req_type;
        req_ch.node_a <= w.node_a;
        req_ch.node_b <= w.node_b;
        req_ch.parent_index <= w.parent_index;
        req_ch.has_parent <= w.has_parent;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
  end

  // response monitor and receiver stall pattern
  rx_mode_e rx_mode = RX_OPEN;
  int rx_phase_left = 0;
  int rx_cycle = 0;
  int hold_left = 0;
  bit held_off = 1'b0;

  always @(posedge clk) begin : watch_answers
    lca_answer_t exp_ans;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        n_answers++;
        if (expected_answers.size() == 0) begin
          errors++;
          $display("%0t: unexpected answer ancestor %0d found %0d", $time,
                   rsp_ch.ancestor, rsp_ch.found);
        end else begin
          exp_ans = expected_answers.pop_front();
          if (exp_ans.found) n_found++;
          else n_missed++;
          if (rsp_ch.ancestor !== exp_ans.ancestor) begin
            errors++;
            $display("%0t: ancestor mismatch expected %0d actual %0d", $time,
                     exp_ans.ancestor, rsp_ch.ancestor);
          end
          if (rsp_ch.found !== exp_ans.found) begin
            errors++;
            $display("%0t: found mismatch expected %0d actual %0d", $time,
                     exp_ans.found, rsp_ch.found);
          end
        end
      end

      // one long hold-off so the unit backs up into its input
      rx_cycle++;
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (!held_off && n_answers >= 150) begin
        held_off = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
        rsp_ch.ready <= 1'b0;
      end else begin
        if (rx_phase_left == 0) begin
          rx_mode = rx_mode_e'($urandom_range(3));
          rx_phase_left = $urandom_range(20, 120);
        end else begin
          rx_phase_left--;
        end
        case (rx_mode)
          RX_OPEN:   rsp_ch.ready <= 1'b1;
          RX_THIRDS: rsp_ch.ready <= (rx_cycle % 3 == 0);
          RX_COIN:   rsp_ch.ready <= 1'($urandom_range(1));
          default:   rsp_ch.ready <= ($urandom_range(7) != 0);
        endcase
      end
    end
  end

  // stimulus and end of run
  initial begin : run_regression
    int node;
    int r;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_WRITE;
    req_ch.node_a = '0;
    req_ch.node_b = '0;
    req_ch.parent_index = '0;
    req_ch.has_parent = 1'b0;
    rsp_ch.ready = 1'b0;

    // directed: equal nodes need no table entry
    push_query(0, 0);
    push_query(255, 255);
    // two roots at the extremes, so the query lands in different trees
    push_write(0, 255, 1'b0);
    push_write(255, 0, 1'b0);
    push_query(0, 255);
    // small tree under node 0
    push_write(1, 0, 1'b1);
    push_write(2, 1, 1'b1);
    push_write(3, 0, 1'b1);
    push_query(2, 3);
    push_query(2, 1);
    push_query(1, 2);
    push_write(255, 2, 1'b1);
    push_query(255, 3);
    // self loop and two-node cycle run into the step bound
    push_write(4, 4, 1'b1);
    push_write(5, 4, 1'b1);
    push_query(5, 0);
    push_write(7, 8, 1'b1);
    push_write(8, 7, 1'b1);
    push_query(8, 0);
    // parent above its node, still terminating
    push_write(6, 255, 1'b1);
    push_query(6, 3);
    // second tree rooted at 9
    push_write(9, 200, 1'b0);
    push_write(10, 9, 1'b1);
    push_query(10, 2);

    // fill the whole table with a well-formed forest
    for (node = 0; node < MAX_NODES; node++) begin
      if (node == 0 || $urandom_range(99) < 6) push_write(node, $urandom_range(255), 1'b0);
      else push_write(node, $urandom_range(node - 1, 0), 1'b1);
    end

    // random mix of queries and parent updates
    repeat (770) begin
      r = $urandom_range(99);
      if (r < 60) begin
        r = $urandom_range(99);
        if (r < 15) begin
          node = $urandom_range(255);
          push_query(node, node);
        end else if (r < 50) begin
          push_query($urandom_range(31), $urandom_range(31));
        end else begin
          push_query($urandom_range(255), $urandom_range(255));
        end
      end else begin
        node = $urandom_range(255);
        r = $urandom_range(99);
        if (node == 0 || r < 8) push_write(node, $urandom_range(255), 1'b0);
        else if (r < 12) push_write(node, $urandom_range(255, node), 1'b1);
        else push_write(node, $urandom_range(node - 1, 0), 1'b1);
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pending_words.size() != 0 || req_ch.valid) @(posedge clk);
    while (expected_answers.size() != 0) @(posedge clk);
    repeat (WALK_CYCLES) @(posedge clk);

    $display("accepted %0d parent writes and %0d queries, checked %0d answers",
             n_writes, n_queries, n_answers);
    $display("%0d answers met at a common ancestor, %0d reported none", n_found, n_missed);
    if (errors == 0 && expected_answers.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("timeout with %0d answers still expected", expected_answers.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
